### rtl/tre_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tre_pkg;

    // field widths
    localparam int ADDR_W     = 15;
    localparam int WORD_W     = 16;
    localparam int ROWS_W     = 8;
    localparam int TBLC_W     = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    // register reset values
    localparam logic [ADDR_W-1:0] START_RESET  = 15'd1984;
    localparam logic [ROWS_W-1:0] ROWS_RESET   = 8'd32;
    localparam logic [TBLC_W-1:0] TABLES_RESET = 3'd4;

    // parameter defaults
    localparam int ROW_COLUMNS_DEF  = 64;
    localparam int TABLE_STRIDE_DEF = 2048;
    localparam int MAX_TABLES_DEF   = 4;
    localparam int QUEUE_DEPTH      = 2;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START  = 2'd0,
        REG_ROWS   = 2'd1,
        REG_TABLES = 2'd2
    } cfg_reg_t;

    // decoder phase, one-hot
    typedef enum logic [2:0] {
        PH_LIT = 3'b001,
        PH_VAL = 3'b010,
        PH_CNT = 3'b100
    } phase_t;

    // configuration seen by the write sequencer
    typedef struct packed {
        logic [ADDR_W-1:0] start_word_address;
        logic [ROWS_W-1:0] row_count;
        logic [TBLC_W-1:0] table_count;
    } cfg_t;

endpackage

`default_nettype wire

### rtl/tre_channels.sv
`timescale 1ns / 1ps
`default_nettype none

// compressed source word channel
interface tre_src_if import tre_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] source_word;

    modport source (output valid, output source_word, input ready);
    modport sink   (input valid, input source_word, output ready);
endinterface

// tile RAM write channel
interface tre_write_if import tre_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] write_address;
    logic [WORD_W-1:0] tile_value;
    logic              run_last;
    logic              map_done;

    modport source (output valid, output write_address, output tile_value,
                    output run_last, output map_done, input ready);
    modport sink   (input valid, input write_address, input tile_value,
                    input run_last, input map_done, output ready);
endinterface

`default_nettype wire

### rtl/tre_front.sv
`timescale 1ns / 1ps
`default_nettype none

module tre_front import tre_pkg::*;
#(
    parameter  int ROW_COLUMNS = ROW_COLUMNS_DEF,
    localparam int CNT_W       = $clog2(ROW_COLUMNS + 1)
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    tre_src_if.sink               src,
    output logic                  cmd_valid,
    input  wire logic             cmd_ready,
    output logic [WORD_W-1:0]     cmd_value,
    output logic [CNT_W-1:0]      cmd_copies
);

    phase_t            phase_reg, phase_next;
    logic [WORD_W-1:0] held_reg, held_next;
    logic              accept;
    logic              is_count;
    logic              is_escape_phase;

    assign src.ready = cmd_ready;
    assign accept    = src.valid && cmd_ready;

    assign is_count        = (phase_reg == PH_CNT);
    assign is_escape_phase = (phase_reg == PH_VAL);

    // a word becomes a command when it is a literal or a run count
    assign cmd_valid = src.valid &&
                       (is_count || (!is_escape_phase && src.source_word != '0));
    assign cmd_value = is_count ? held_reg : src.source_word;

    // copies clipped to one row, the sequencer clips further to the room left
    always_comb
    begin
        if (!is_count)
            cmd_copies = CNT_W'(1);
        else if (src.source_word >= WORD_W'(ROW_COLUMNS - 1))
            cmd_copies = CNT_W'(ROW_COLUMNS);
        else
            cmd_copies = src.source_word[CNT_W-1:0] + CNT_W'(1);
    end

    // phase decoder
    always_comb
    begin
        phase_next = phase_reg;
        held_next  = held_reg;
        if (accept)
        begin
            unique case (phase_reg)
                PH_VAL:
                begin
                    held_next  = src.source_word;
                    phase_next = PH_CNT;
                end
                PH_CNT:
                    phase_next = PH_LIT;
                default:
                    phase_next = (src.source_word == '0) ? PH_VAL : PH_LIT;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LIT;
            held_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

endmodule

`default_nettype wire

### rtl/tre_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module tre_queue
#(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 2,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [WIDTH-1:0] in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [WIDTH-1:0]      out_data
);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             push, pop;

    assign in_ready  = (fill_reg != CNT_W'(DEPTH));
    assign out_valid = (fill_reg != '0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            fill_next = fill_reg + CNT_W'(1);
        else if (pop && !push)
            fill_next = fill_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= in_data;
    end

endmodule

`default_nettype wire

### rtl/tre_back.sv
`timescale 1ns / 1ps
`default_nettype none

module tre_back import tre_pkg::*;
#(
    parameter  int ROW_COLUMNS  = ROW_COLUMNS_DEF,
    parameter  int TABLE_STRIDE = TABLE_STRIDE_DEF,
    parameter  int MAX_TABLES   = MAX_TABLES_DEF,
    localparam int CNT_W        = $clog2(ROW_COLUMNS + 1),
    localparam int COL_W        = $clog2(ROW_COLUMNS),
    localparam int TBL_W        = (MAX_TABLES > 1) ? $clog2(MAX_TABLES) : 1
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cfg_t              cfg,
    input  wire logic              cmd_valid,
    output logic                   cmd_ready,
    input  wire logic [WORD_W-1:0] cmd_value,
    input  wire logic [CNT_W-1:0]  cmd_copies,
    tre_write_if.source            dst
);

    localparam int TE_W = TBL_W + 1;

    logic              busy_reg, busy_next;
    logic [WORD_W-1:0] value_reg;
    logic [CNT_W-1:0]  left_reg, left_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROWS_W-1:0] row_reg, row_next;
    logic [TBL_W-1:0]  tbl_reg, tbl_next;

    logic              out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0] out_addr_reg;
    logic [WORD_W-1:0] out_value_reg;
    logic              out_last_reg;
    logic              out_done_reg;

    logic              load, fire;
    logic              col_wrap, row_wrap, tbl_wrap, last;
    logic [ROWS_W-1:0] rows_eff;
    logic [TE_W-1:0]   tables_eff;
    logic [ROWS_W:0]   row_inc;
    logic [TE_W-1:0]   tbl_inc;
    logic [ADDR_W-1:0] tbl_off, row_off, addr;

    // effective limits
    assign rows_eff = (cfg.row_count == '0) ? ROWS_W'(1) : cfg.row_count;

    always_comb
    begin
        if (cfg.table_count == '0)
            tables_eff = TE_W'(1);
        else if (32'(cfg.table_count) > MAX_TABLES)
            tables_eff = TE_W'(MAX_TABLES);
        else
            tables_eff = TE_W'(cfg.table_count);
    end

    // write address of the current position
    assign tbl_off = ADDR_W'(tbl_reg * TABLE_STRIDE);
    assign row_off = ADDR_W'(row_reg * ROW_COLUMNS);
    assign addr    = cfg.start_word_address + tbl_off - row_off + ADDR_W'(col_reg);

    // position wrap detection
    assign row_inc  = {1'b0, row_reg} + (ROWS_W + 1)'(1);
    assign tbl_inc  = {1'b0, tbl_reg} + TE_W'(1);
    assign col_wrap = (col_reg == COL_W'(ROW_COLUMNS - 1));
    assign row_wrap = col_wrap && (row_inc >= {1'b0, rows_eff});
    assign tbl_wrap = row_wrap && (tbl_inc >= tables_eff);
    assign last     = (left_reg == CNT_W'(1)) || col_wrap;

    assign cmd_ready = !busy_reg;
    assign load      = cmd_valid && !busy_reg;
    assign fire      = busy_reg && (!out_valid_reg || dst.ready);

    // run sequencer
    always_comb
    begin
        busy_next = busy_reg;
        left_next = left_reg;
        col_next  = col_reg;
        row_next  = row_reg;
        tbl_next  = tbl_reg;
        if (load)
        begin
            busy_next = 1'b1;
            left_next = cmd_copies;
        end
        else if (fire)
        begin
            left_next = left_reg - CNT_W'(1);
            if (last)
                busy_next = 1'b0;
            if (col_wrap)
            begin
                col_next = '0;
                if (row_wrap)
                begin
                    row_next = '0;
                    tbl_next = tbl_wrap ? '0 : tbl_inc[TBL_W-1:0];
                end
                else
                    row_next = row_inc[ROWS_W-1:0];
            end
            else
                col_next = col_reg + COL_W'(1);
        end
    end

    always_comb
    begin
        if (fire)
            out_valid_next = 1'b1;
        else if (dst.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            left_reg      <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            tbl_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            left_reg      <= left_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            tbl_reg       <= tbl_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (load)
            value_reg <= cmd_value;
        if (fire)
        begin
            out_addr_reg  <= addr;
            out_value_reg <= value_reg;
            out_last_reg  <= last;
            out_done_reg  <= tbl_wrap;
        end
    end

    assign dst.valid         = out_valid_reg;
    assign dst.write_address = out_addr_reg;
    assign dst.tile_value    = out_value_reg;
    assign dst.run_last      = out_last_reg;
    assign dst.map_done      = out_done_reg;

endmodule

`default_nettype wire

### rtl/tilemap_rle_expander_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Tilemap run-length expander.
// src carries compressed 16-bit words; dst carries tile RAM word writes,
// each with its address, tile value, run_last and map_done.
// A nonzero word is one literal write. A zero word, then a value word,
// then a count word give count+1 writes of the value, cut at row end.
// The decoder accepts a word per cycle while its two-entry command queue
// has room; escape and value words make no command.
// The write sequencer takes a command in a load step, then makes one
// write per cycle while dst is ready, taking no new command until the
// run's last write. An accepted literal passes the command queue, the
// load step and the output register before it appears on dst.
// The user must write configuration via cfg_write/cfg_index/cfg_data
// only while idle, which the block does not enforce; index 3 is ignored.
// Reset restores the register defaults and rewinds to the first column
// of the first row of table zero. When dst stalls the write is held in the
// output register, the sequencer waits, and src keeps taking words until
// the queue is full.
module tilemap_rle_expander_core import tre_pkg::*;
#(
    parameter int ROW_COLUMNS  = ROW_COLUMNS_DEF,
    parameter int TABLE_STRIDE = TABLE_STRIDE_DEF,
    parameter int MAX_TABLES   = MAX_TABLES_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    tre_src_if.sink                    src,
    tre_write_if.source                dst
);

    localparam int CNT_W = $clog2(ROW_COLUMNS + 1);
    localparam int CMD_W = WORD_W + CNT_W;

    cfg_t              cfg_reg;
    logic              q_in_valid, q_in_ready;
    logic              q_out_valid, q_out_ready;
    logic [WORD_W-1:0] f_value;
    logic [CNT_W-1:0]  f_copies;
    logic [CMD_W-1:0]  q_out_data;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_word_address <= START_RESET;
            cfg_reg.row_count          <= ROWS_RESET;
            cfg_reg.table_count        <= TABLES_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_START:  cfg_reg.start_word_address <= cfg_data[ADDR_W-1:0];
                REG_ROWS:   cfg_reg.row_count          <= cfg_data[ROWS_W-1:0];
                REG_TABLES: cfg_reg.table_count        <= cfg_data[TBLC_W-1:0];
                default:    cfg_reg                    <= cfg_reg;
            endcase
        end
    end

    // word decoder
    tre_front #(
        .ROW_COLUMNS (ROW_COLUMNS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .src        (src),
        .cmd_valid  (q_in_valid),
        .cmd_ready  (q_in_ready),
        .cmd_value  (f_value),
        .cmd_copies (f_copies)
    );

    // command queue
    tre_queue #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_in_valid),
        .in_ready  (q_in_ready),
        .in_data   ({f_value, f_copies}),
        .out_valid (q_out_valid),
        .out_ready (q_out_ready),
        .out_data  (q_out_data)
    );

    // write sequencer
    tre_back #(
        .ROW_COLUMNS  (ROW_COLUMNS),
        .TABLE_STRIDE (TABLE_STRIDE),
        .MAX_TABLES   (MAX_TABLES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .cmd_valid  (q_out_valid),
        .cmd_ready  (q_out_ready),
        .cmd_value  (q_out_data[CMD_W-1:CNT_W]),
        .cmd_copies (q_out_data[CNT_W-1:0]),
        .dst        (dst)
    );

    // the final write of a map always ends its run
    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        dst.valid && dst.map_done |-> dst.run_last)
        else $error("map_done without run_last");

    // a command always carries between one copy and one row of copies
    a_cmd_copies: assert property (@(posedge clk) disable iff (!rst_n)
        q_out_valid |-> (q_out_data[CNT_W-1:0] != '0) &&
                        (q_out_data[CNT_W-1:0] <= CNT_W'(ROW_COLUMNS)))
        else $error("command copy count out of range");

    // a literal word always turns into a queued command
    a_literal_queued: assert property (@(posedge clk) disable iff (!rst_n)
        src.valid && src.ready && (src.source_word != '0) && !q_in_valid
        |-> $past(src.valid && src.ready && src.source_word == '0) ||
            $past(q_in_valid && q_in_ready && f_copies == CNT_W'(1)) == 1'b0)
        else $error("literal word dropped by decoder");

endmodule

`default_nettype wire
